FILE: rtl/dtu_pkg.sv
// types and codes shared by the debug trigger unit
package dtu_pkg;

  typedef enum logic [3:0] {
    FUNC_INSN       = 4'd0,
    FUNC_MEMWRITE   = 4'd1,
    FUNC_INTERRUPT  = 4'd2,
    FUNC_STEP       = 4'd3,
    FUNC_CONTINUE   = 4'd4,
    FUNC_CLEARALL   = 4'd5,
    FUNC_LOAD_BP    = 4'd6,
    FUNC_LOAD_WATCH = 4'd7,
    FUNC_LOAD_INTBP = 4'd8,
    FUNC_READ_RING  = 4'd9
  } func_e;

  typedef enum logic [2:0] {
    CAUSE_NONE  = 3'd0,
    CAUSE_STEP  = 3'd1,
    CAUSE_CODE  = 3'd2,
    CAUSE_WATCH = 3'd3,
    CAUSE_INT   = 3'd4
  } cause_e;

  // configuration register index, taken from paddr bit 2
  localparam logic CFG_IDX_ENABLE = 1'b0;

  localparam int unsigned LOG_BITS = 8;

  typedef struct packed {
    logic        valid;
    logic [15:0] cs;
    logic [15:0] ip;
  } code_bp_t;

  typedef struct packed {
    logic        valid;
    logic [19:0] lo;
    logic [19:0] hi;
    logic        pause;
  } watch_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] vec;
    logic [7:0] ah;
    logic       any;
  } int_bp_t;

  typedef struct packed {
    logic [7:0]  vec;
    logic [15:0] ax;
    logic [15:0] cs;
    logic [15:0] ip;
    logic [15:0] ds;
  } ring_entry_t;

endpackage

FILE: rtl/debug_trigger_unit_core.sv
// debug trigger unit: breakpoint, watch and interrupt tables, single step, interrupt ring
//
// usage
// - one event or command beat enters on the input channel (in_valid_i / in_stall_o);
//   func_i selects instruction, memory write, interrupt, step, continue, clear all,
//   table loads or a ring read
// - exactly one result beat leaves on the output channel (out_valid_o / out_stall_i)
//   for every input beat, in order
// - the result is registered, shown after the edge that accepts the beat; a new beat
//   can be taken every cycle while the receiver does not stall, set by the single result
//   register behind the table comparators and the registered ring memory read
// - when the receiver stalls, the result holds and the input is stalled until the
//   result is taken; a beat is accepted in the same cycle the waiting result leaves
// - agent_enable (apb byte address 0, bit 0) gates instruction, write and interrupt
//   events; change it only while no beat is in flight
// - reset clears all table valid bits, the step machine, the ring head and fill
//   count, and sets agent_enable; ring memory contents are not cleared, entries
//   beyond the fill count read as zero
module debug_trigger_unit_core #(
  parameter int unsigned CODE_BP_SLOTS = 8,
  parameter int unsigned WATCH_SLOTS   = 8,
  parameter int unsigned INT_BP_SLOTS  = 8,
  parameter int unsigned RING_DEPTH    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  func_i,
  input  logic [5:0]  slot_i,
  input  logic        option_i,
  input  logic [15:0] seg_cs_i,
  input  logic [15:0] offset_ip_i,
  input  logic [15:0] seg_ds_i,
  input  logic [19:0] phys_addr_i,
  input  logic [19:0] phys_high_i,
  input  logic [7:0]  old_byte_i,
  input  logic [7:0]  new_byte_i,
  input  logic [7:0]  int_number_i,
  input  logic [15:0] ax_value_i,

  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trap_o,
  output logic [2:0]  cause_o,
  output logic [2:0]  hit_slot_o,
  output logic [7:0]  log_hits_o,
  output logic [6:0]  ring_count_o,
  output logic [7:0]  ring_vector_o,
  output logic [15:0] ring_ax_o,
  output logic [15:0] ring_cs_o,
  output logic [15:0] ring_ip_o,
  output logic [15:0] ring_ds_o
);

  import dtu_pkg::*;

  localparam int unsigned RingAw = $clog2(RING_DEPTH);
  localparam int unsigned RingFw = $clog2(RING_DEPTH + 1);
  // wide enough for head + depth - 1 - slot and the slot compare
  localparam int unsigned RingIw = ((RingAw > 6) ? RingAw : 6) + 2;

  // configuration
  logic agent_enable_q;
  logic cfg_write;

  // handshake
  logic  accept;
  logic  out_valid_q;
  func_e func;

  // tables and step machine
  code_bp_t code_bp_q [CODE_BP_SLOTS];
  code_bp_t code_bp_d [CODE_BP_SLOTS];
  watch_t   watch_q   [WATCH_SLOTS];
  watch_t   watch_d   [WATCH_SLOTS];
  int_bp_t  int_bp_q  [INT_BP_SLOTS];
  int_bp_t  int_bp_d  [INT_BP_SLOTS];
  logic     step_armed_q, step_armed_d;
  logic     step_pending_q, step_pending_d;

  // ring bookkeeping
  logic [RingAw-1:0] ring_head_q, ring_head_d;
  logic [RingFw-1:0] ring_fill_q, ring_fill_d;
  logic              ring_wr;
  ring_entry_t       ring_wr_data;
  ring_entry_t       ring_mem [RING_DEPTH];
  ring_entry_t       ring_rd_q;
  logic [RingIw-1:0] rd_sum;
  logic [RingIw-1:0] rd_wrap;
  logic [RingAw-1:0] rd_idx;
  logic              rd_hit;

  // result
  logic          trap_d, trap_q;
  cause_e        cause_d, cause_q;
  logic [2:0]    hit_d, hit_q;
  logic [7:0]    logs_d, logs_q;
  logic [6:0]    count_q;
  logic          rd_valid_q;

  // ---------------------------------------------------------------------------
  // configuration port: single register, zero wait states
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == CFG_IDX_ENABLE) ? {31'd0, agent_enable_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agent_enable_q <= 1'b1;
    end else if (cfg_write && (paddr[2] == CFG_IDX_ENABLE)) begin
      agent_enable_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: take a beat when the result slot is empty or being drained
  // ---------------------------------------------------------------------------
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign func       = func_e'(func_i);

  // ---------------------------------------------------------------------------
  // ring read address: age 0 is the entry just behind the head
  // ---------------------------------------------------------------------------
  assign rd_sum  = RingIw'(ring_head_q) + RingIw'(RING_DEPTH - 1) - RingIw'(slot_i);
  assign rd_wrap = (rd_sum >= RingIw'(RING_DEPTH)) ? (rd_sum - RingIw'(RING_DEPTH)) : rd_sum;
  assign rd_idx  = rd_wrap[RingAw-1:0];
  assign rd_hit  = (func == FUNC_READ_RING) && (RingIw'(slot_i) < RingIw'(ring_fill_q));

  assign ring_wr_data = '{vec: int_number_i, ax: ax_value_i, cs: seg_cs_i,
                          ip: offset_ip_i, ds: seg_ds_i};

  // ---------------------------------------------------------------------------
  // event decode, table compare and next state
  // ---------------------------------------------------------------------------
  always_comb begin
    logic found;
    logic match;

    code_bp_d      = code_bp_q;
    watch_d        = watch_q;
    int_bp_d       = int_bp_q;
    step_armed_d   = step_armed_q;
    step_pending_d = step_pending_q;
    ring_head_d    = ring_head_q;
    ring_fill_d    = ring_fill_q;
    ring_wr        = 1'b0;
    trap_d         = 1'b0;
    cause_d        = CAUSE_NONE;
    hit_d          = '0;
    logs_d         = '0;
    found          = 1'b0;
    match          = 1'b0;

    unique case (func)
      FUNC_INSN: begin
        if (agent_enable_q) begin
          if (step_pending_q) begin
            step_pending_d = 1'b0;
            step_armed_d   = 1'b0;
            trap_d         = 1'b1;
            cause_d        = CAUSE_STEP;
          end else if (step_armed_q) begin
            step_armed_d   = 1'b0;
            step_pending_d = 1'b1;
          end else begin
            // walk down so the lowest matching slot wins
            for (int i = CODE_BP_SLOTS - 1; i >= 0; i--) begin
              if (code_bp_q[i].valid && (code_bp_q[i].cs == seg_cs_i) &&
                  (code_bp_q[i].ip == offset_ip_i)) begin
                trap_d  = 1'b1;
                cause_d = CAUSE_CODE;
                hit_d   = 3'(i);
              end
            end
          end
        end
      end

      FUNC_MEMWRITE: begin
        if (agent_enable_q && (old_byte_i != new_byte_i)) begin
          for (int i = 0; i < WATCH_SLOTS; i++) begin
            match = watch_q[i].valid && (phys_addr_i >= watch_q[i].lo) &&
                    (phys_addr_i <= watch_q[i].hi);
            if (match && !found) begin
              if (watch_q[i].pause) begin
                found   = 1'b1;
                trap_d  = 1'b1;
                cause_d = CAUSE_WATCH;
                hit_d   = 3'(i);
              end else if (i < LOG_BITS) begin
                logs_d[i[2:0]] = 1'b1;
              end
            end
          end
        end
      end

      FUNC_INTERRUPT: begin
        if (agent_enable_q) begin
          ring_wr     = 1'b1;
          ring_head_d = (ring_head_q == RingAw'(RING_DEPTH - 1)) ? '0 : ring_head_q + 1'b1;
          if (ring_fill_q != RingFw'(RING_DEPTH)) begin
            ring_fill_d = ring_fill_q + 1'b1;
          end
          for (int i = INT_BP_SLOTS - 1; i >= 0; i--) begin
            if (int_bp_q[i].valid && (int_bp_q[i].vec == int_number_i) &&
                (int_bp_q[i].any || (int_bp_q[i].ah == ax_value_i[15:8]))) begin
              trap_d  = 1'b1;
              cause_d = CAUSE_INT;
              hit_d   = 3'(i);
            end
          end
        end
      end

      FUNC_STEP: begin
        step_armed_d   = 1'b1;
        step_pending_d = 1'b0;
      end

      FUNC_CONTINUE: begin
        step_armed_d   = 1'b0;
        step_pending_d = 1'b0;
      end

      FUNC_CLEARALL: begin
        for (int i = 0; i < CODE_BP_SLOTS; i++) code_bp_d[i].valid = 1'b0;
        for (int i = 0; i < WATCH_SLOTS; i++)   watch_d[i].valid   = 1'b0;
        for (int i = 0; i < INT_BP_SLOTS; i++)  int_bp_d[i].valid  = 1'b0;
        step_armed_d   = 1'b0;
        step_pending_d = 1'b0;
      end

      FUNC_LOAD_BP: begin
        for (int i = 0; i < CODE_BP_SLOTS; i++) begin
          if (7'(slot_i) == 7'(i)) begin
            code_bp_d[i] = '{valid: 1'b1, cs: seg_cs_i, ip: offset_ip_i};
          end
        end
      end

      FUNC_LOAD_WATCH: begin
        for (int i = 0; i < WATCH_SLOTS; i++) begin
          if (7'(slot_i) == 7'(i)) begin
            watch_d[i] = '{valid: 1'b1, lo: phys_addr_i, hi: phys_high_i, pause: option_i};
          end
        end
      end

      FUNC_LOAD_INTBP: begin
        for (int i = 0; i < INT_BP_SLOTS; i++) begin
          if (7'(slot_i) == 7'(i)) begin
            int_bp_d[i] = '{valid: 1'b1, vec: int_number_i, ah: ax_value_i[15:8],
                            any: option_i};
          end
        end
      end

      FUNC_READ_RING: begin
        // data comes from the registered memory read
      end

      default: begin
        // unused codes change nothing
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // state registers, advanced once per accepted beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_BP_SLOTS; i++) code_bp_q[i] <= '0;
      for (int i = 0; i < WATCH_SLOTS; i++)   watch_q[i]   <= '0;
      for (int i = 0; i < INT_BP_SLOTS; i++)  int_bp_q[i]  <= '0;
      step_armed_q   <= 1'b0;
      step_pending_q <= 1'b0;
      ring_head_q    <= '0;
      ring_fill_q    <= '0;
    end else if (accept) begin
      code_bp_q      <= code_bp_d;
      watch_q        <= watch_d;
      int_bp_q       <= int_bp_d;
      step_armed_q   <= step_armed_d;
      step_pending_q <= step_pending_d;
      ring_head_q    <= ring_head_d;
      ring_fill_q    <= ring_fill_d;
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && ring_wr) begin
      ring_mem[ring_head_q] <= ring_wr_data;
    end
    if (accept && rd_hit) begin
      ring_rd_q <= ring_mem[rd_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      trap_q     <= trap_d;
      cause_q    <= cause_d;
      hit_q      <= hit_d;
      logs_q     <= logs_d;
      count_q    <= 7'(ring_fill_d);
      rd_valid_q <= rd_hit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trap_o        = trap_q;
  assign cause_o       = cause_q;
  assign hit_slot_o    = hit_q;
  assign log_hits_o    = logs_q;
  assign ring_count_o  = count_q;
  assign ring_vector_o = rd_valid_q ? ring_rd_q.vec : 8'd0;
  assign ring_ax_o     = rd_valid_q ? ring_rd_q.ax  : 16'd0;
  assign ring_cs_o     = rd_valid_q ? ring_rd_q.cs  : 16'd0;
  assign ring_ip_o     = rd_valid_q ? ring_rd_q.ip  : 16'd0;
  assign ring_ds_o     = rd_valid_q ? ring_rd_q.ds  : 16'd0;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_step_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_armed_q && step_pending_q))
    else $error("step armed and pending at once");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_fill_q <= RingFw'(RING_DEPTH))
    else $error("ring fill beyond depth");

  a_trap_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (trap_o == (cause_o != CAUSE_NONE)))
    else $error("trap and cause disagree");

  a_logs_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (log_hits_o != 8'd0)) |-> ((cause_o == CAUSE_NONE) ||
                                               (cause_o == CAUSE_WATCH)))
    else $error("log hits on a non-write result");

  a_step_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func == FUNC_STEP)) |=> (step_armed_q && !step_pending_q))
    else $error("step command did not arm");

endmodule

FILE: tb/tb_top.sv
// testbench for the debug trigger unit: every result beat checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import dtu_pkg::*;

  localparam int unsigned CODE_SLOTS  = 8;
  localparam int unsigned WATCH_CNT   = 8;
  localparam int unsigned INTBP_SLOTS = 8;
  localparam int unsigned RING_SLOTS  = 64;
  localparam int unsigned LIMIT       = 300000;

  // one input beat, field for field as on the ports
  typedef struct {
    logic [3:0]  func;
    logic [5:0]  slot;
    logic        option;
    logic [15:0] seg_cs;
    logic [15:0] offset_ip;
    logic [15:0] seg_ds;
    logic [19:0] phys_addr;
    logic [19:0] phys_high;
    logic [7:0]  old_byte;
    logic [7:0]  new_byte;
    logic [7:0]  int_number;
    logic [15:0] ax_value;
  } beat_t;

  // one result beat
  typedef struct {
    logic        trap;
    logic [2:0]  cause;
    logic [2:0]  hit_slot;
    logic [7:0]  log_hits;
    logic [6:0]  ring_count;
    logic [7:0]  ring_vector;
    logic [15:0] ring_ax;
    logic [15:0] ring_cs;
    logic [15:0] ring_ip;
    logic [15:0] ring_ds;
  } outcome_t;

  // mirror of the trigger tables, step machine and interrupt ring;
  // each accepted beat is turned into the result it must produce
  class trigger_scoreboard;
    logic        unit_on;
    code_bp_t    code_tab[CODE_SLOTS];
    watch_t      watch_tab[WATCH_CNT];
    int_bp_t     intbp_tab[INTBP_SLOTS];
    ring_entry_t ring_mem[RING_SLOTS];
    logic [5:0]  ring_wr;
    logic [6:0]  ring_used;
    logic        step_wait;
    logic        step_due;
    outcome_t    expected_q[$];
    int unsigned errors;

    function new();
      unit_on   = 1'b1;
      ring_wr   = '0;
      ring_used = '0;
      errors    = 0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
      clear_tables();
    endfunction

    function void clear_tables();
      foreach (code_tab[i]) code_tab[i] = '0;
      foreach (watch_tab[i]) watch_tab[i] = '0;
      foreach (intbp_tab[i]) intbp_tab[i] = '0;
      step_wait = 1'b0;
      step_due  = 1'b0;
    endfunction

    function int unsigned waiting();
      return expected_q.size();
    endfunction

    function void note_beat(beat_t b);
      outcome_t o;
      logic [5:0] idx;
      int i;
      o = '{default: '0};
      case (b.func)
        FUNC_INSN: if (unit_on) begin
          // a pending step wins over any breakpoint
          if (step_due) begin
            step_due  = 1'b0;
            step_wait = 1'b0;
            o.trap    = 1'b1;
            o.cause   = CAUSE_STEP;
          end else if (step_wait) begin
            step_wait = 1'b0;
            step_due  = 1'b1;
          end else begin
            for (i = 0; i < CODE_SLOTS; i++) begin
              if (code_tab[i].valid && code_tab[i].cs == b.seg_cs &&
                  code_tab[i].ip == b.offset_ip) begin
                o.trap     = 1'b1;
                o.cause    = CAUSE_CODE;
                o.hit_slot = i[2:0];
                break;
              end
            end
          end
        end
        FUNC_MEMWRITE: if (unit_on && b.old_byte != b.new_byte) begin
          for (i = 0; i < WATCH_CNT; i++) begin
            if (!watch_tab[i].valid || b.phys_addr < watch_tab[i].lo ||
                b.phys_addr > watch_tab[i].hi) continue;
            if (watch_tab[i].pause) begin
              o.trap     = 1'b1;
              o.cause    = CAUSE_WATCH;
              o.hit_slot = i[2:0];
              break;
            end
            if (i < LOG_BITS) o.log_hits[i] = 1'b1;
          end
        end
        FUNC_INTERRUPT: if (unit_on) begin
          ring_mem[ring_wr] = '{b.int_number, b.ax_value, b.seg_cs, b.offset_ip, b.seg_ds};
          ring_wr = ring_wr + 6'd1;
          if (ring_used < RING_SLOTS) ring_used = ring_used + 7'd1;
          for (i = 0; i < INTBP_SLOTS; i++) begin
            if (!intbp_tab[i].valid || intbp_tab[i].vec != b.int_number) continue;
            if (!intbp_tab[i].any && intbp_tab[i].ah != b.ax_value[15:8]) continue;
            o.trap     = 1'b1;
            o.cause    = CAUSE_INT;
            o.hit_slot = i[2:0];
            break;
          end
        end
        FUNC_STEP: begin
          step_wait = 1'b1;
          step_due  = 1'b0;
        end
        FUNC_CONTINUE: begin
          step_wait = 1'b0;
          step_due  = 1'b0;
        end
        FUNC_CLEARALL: clear_tables();
        FUNC_LOAD_BP: if (b.slot < CODE_SLOTS)
          code_tab[b.slot] = '{1'b1, b.seg_cs, b.offset_ip};
        FUNC_LOAD_WATCH: if (b.slot < WATCH_CNT)
          watch_tab[b.slot] = '{1'b1, b.phys_addr, b.phys_high, b.option};
        FUNC_LOAD_INTBP: if (b.slot < INTBP_SLOTS)
          intbp_tab[b.slot] = '{1'b1, b.int_number, b.ax_value[15:8], b.option};
        FUNC_READ_RING: if (b.slot < ring_used) begin
          idx           = ring_wr - 6'd1 - b.slot;
          o.ring_vector = ring_mem[idx].vec;
          o.ring_ax     = ring_mem[idx].ax;
          o.ring_cs     = ring_mem[idx].cs;
          o.ring_ip     = ring_mem[idx].ip;
          o.ring_ds     = ring_mem[idx].ds;
        end
        default: ;
      endcase
      o.ring_count = ring_used;
      expected_q.insert(expected_q.size(), o);
    endfunction

    function void match_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(outcome_t got);
      outcome_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      match_field("trap", 16'(want.trap), 16'(got.trap));
      match_field("cause", 16'(want.cause), 16'(got.cause));
      match_field("hit_slot", 16'(want.hit_slot), 16'(got.hit_slot));
      match_field("log_hits", 16'(want.log_hits), 16'(got.log_hits));
      match_field("ring_count", 16'(want.ring_count), 16'(got.ring_count));
      match_field("ring_vector", 16'(want.ring_vector), 16'(got.ring_vector));
      match_field("ring_ax", want.ring_ax, got.ring_ax);
      match_field("ring_cs", want.ring_cs, got.ring_cs);
      match_field("ring_ip", want.ring_ip, got.ring_ip);
      match_field("ring_ds", want.ring_ds, got.ring_ds);
    endfunction
  endclass

  // clock, reset and everything driven into the block, all known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic        in_valid  = 1'b0;
  logic        out_stall = 1'b0;
  beat_t       cur       = '{default: '0};

  logic [31:0] prdata;
  logic        pready;
  logic        in_stall;
  logic        out_valid;
  outcome_t    seen;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycles        = 0;

  trigger_scoreboard sb = new();

  debug_trigger_unit_core #(
    .CODE_BP_SLOTS (CODE_SLOTS),
    .WATCH_SLOTS   (WATCH_CNT),
    .INT_BP_SLOTS  (INTBP_SLOTS),
    .RING_DEPTH    (RING_SLOTS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (cur.func),
    .slot_i        (cur.slot),
    .option_i      (cur.option),
    .seg_cs_i      (cur.seg_cs),
    .offset_ip_i   (cur.offset_ip),
    .seg_ds_i      (cur.seg_ds),
    .phys_addr_i   (cur.phys_addr),
    .phys_high_i   (cur.phys_high),
    .old_byte_i    (cur.old_byte),
    .new_byte_i    (cur.new_byte),
    .int_number_i  (cur.int_number),
    .ax_value_i    (cur.ax_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .trap_o        (seen.trap),
    .cause_o       (seen.cause),
    .hit_slot_o    (seen.hit_slot),
    .log_hits_o    (seen.log_hits),
    .ring_count_o  (seen.ring_count),
    .ring_vector_o (seen.ring_vector),
    .ring_ax_o     (seen.ring_ax),
    .ring_cs_o     (seen.ring_cs),
    .ring_ip_o     (seen.ring_ip),
    .ring_ds_o     (seen.ring_ds)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // all drive happens at the rising edge, so mid-cycle values are exactly the
  // ones the next edge will see; both monitors sample at the falling edge
  always @(negedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_beat(cur);
    if (rst_n && out_valid && !out_stall) sb.check_beat(seen);
  end

  // watchdog
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // every field random, then the caller shapes the ones that matter
  function automatic beat_t noise_beat(logic [3:0] f);
    beat_t b;
    b.func       = f;
    b.slot       = 6'($urandom);
    b.option     = 1'($urandom);
    b.seg_cs     = 16'($urandom);
    b.offset_ip  = 16'($urandom);
    b.seg_ds     = 16'($urandom);
    b.phys_addr  = 20'($urandom);
    b.phys_high  = 20'($urandom);
    b.old_byte   = 8'($urandom);
    b.new_byte   = 8'($urandom);
    b.int_number = 8'($urandom);
    b.ax_value   = 16'($urandom);
    return b;
  endfunction

  // directed beat: only the data segment is left random
  function automatic beat_t dbeat(logic [3:0] f, logic [5:0] slot, logic opt,
                                  logic [15:0] cs, logic [15:0] ip,
                                  logic [19:0] addr, logic [19:0] high,
                                  logic [7:0] ob, logic [7:0] nb,
                                  logic [7:0] vec, logic [15:0] ax);
    beat_t b;
    b            = noise_beat(f);
    b.slot       = slot;
    b.option     = opt;
    b.seg_cs     = cs;
    b.offset_ip  = ip;
    b.phys_addr  = addr;
    b.phys_high  = high;
    b.old_byte   = ob;
    b.new_byte   = nb;
    b.int_number = vec;
    b.ax_value   = ax;
    return b;
  endfunction

  // mostly a real table slot, now and then any slot from 0 to 63, often past the end
  function automatic logic [5:0] table_slot();
    return ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
  endfunction

  // random beat, biased so that events mostly hit what the tables hold
  function automatic beat_t random_beat();
    beat_t b;
    int unsigned r, k, j;
    logic [19:0] lo, hi;
    logic [20:0] top;
    r = $urandom_range(99);
    if (r < 22)      b = noise_beat(FUNC_INSN);
    else if (r < 42) b = noise_beat(FUNC_MEMWRITE);
    else if (r < 62) b = noise_beat(FUNC_INTERRUPT);
    else if (r < 67) b = noise_beat(FUNC_STEP);
    else if (r < 70) b = noise_beat(FUNC_CONTINUE);
    else if (r < 71) b = noise_beat(FUNC_CLEARALL);
    else if (r < 79) b = noise_beat(FUNC_LOAD_BP);
    else if (r < 87) b = noise_beat(FUNC_LOAD_WATCH);
    else if (r < 93) b = noise_beat(FUNC_LOAD_INTBP);
    else if (r < 98) b = noise_beat(FUNC_READ_RING);
    else             b = noise_beat(4'($urandom_range(15, 10)));
    k = $urandom_range(7);
    j = $urandom_range(7);
    case (b.func)
      FUNC_INSN: if ($urandom_range(99) < 60 && sb.code_tab[k].valid) begin
        b.seg_cs    = sb.code_tab[k].cs;
        b.offset_ip = sb.code_tab[k].ip;
      end
      FUNC_MEMWRITE: begin
        if ($urandom_range(99) < 10) b.new_byte = b.old_byte;
        if ($urandom_range(99) < 70 && sb.watch_tab[k].valid) begin
          lo = sb.watch_tab[k].lo;
          hi = sb.watch_tab[k].hi;
          // range edges and just outside them, else somewhere inside
          case ($urandom_range(5))
            0: b.phys_addr = lo;
            1: b.phys_addr = hi;
            2: b.phys_addr = lo - 20'd1;
            3: b.phys_addr = hi + 20'd1;
            default: if (lo <= hi) b.phys_addr = lo + 20'($urandom % (hi - lo + 1));
          endcase
        end
      end
      FUNC_INTERRUPT: if ($urandom_range(99) < 65 && sb.intbp_tab[k].valid) begin
        b.int_number = sb.intbp_tab[k].vec;
        if (!sb.intbp_tab[k].any || $urandom_range(1)) b.ax_value[15:8] = sb.intbp_tab[k].ah;
      end
      FUNC_LOAD_BP: begin
        b.slot = table_slot();
        // duplicate another slot now and then, so the lowest slot must win
        if ($urandom_range(99) < 25 && sb.code_tab[j].valid) begin
          b.seg_cs    = sb.code_tab[j].cs;
          b.offset_ip = sb.code_tab[j].ip;
        end
      end
      FUNC_LOAD_WATCH: begin
        b.slot = table_slot();
        // overlapping ranges let log-only hits pile up ahead of a pausing one
        if ($urandom_range(99) < 40 && sb.watch_tab[j].valid)
          b.phys_addr = sb.watch_tab[j].lo + 20'($urandom_range(255));
        case ($urandom_range(9))
          0: begin
            b.phys_addr = '0;
            b.phys_high = 20'hFFFFF;
          end
          1: b.phys_high = b.phys_addr - 20'd1 - 20'($urandom_range(255));
          2: b.phys_high = b.phys_addr;
          default: begin
            top = {1'b0, b.phys_addr} + 21'($urandom_range(4095));
            b.phys_high = top[20] ? 20'hFFFFF : top[19:0];
          end
        endcase
      end
      FUNC_LOAD_INTBP: begin
        b.slot = table_slot();
        if ($urandom_range(99) < 40) b.int_number = 8'($urandom_range(3));
      end
      FUNC_READ_RING: if ($urandom_range(99) < 40) b.slot = 6'($urandom_range(3));
      default: ;
    endcase
    return b;
  endfunction

  // sender gaps, geometric in length
  task automatic pause_sender();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // present one beat and hold it until the block takes it
  task automatic send_beat(beat_t b);
    pause_sender();
    in_valid <= 1'b1;
    cur      <= b;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  // drop valid and let every expected result drain out
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the enable register: setup cycle, then access cycle
  task automatic cfg_write(logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_IDX_ENABLE, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.unit_on = v[0];
  endtask

  int unsigned phase_send[3]  = '{8, 87, 0};
  int unsigned phase_stall[3] = '{87, 8, 0};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    send_idle_pct = phase_send[0];
    stall_pct     = phase_stall[0];
    cfg_write(32'd1);

    // ---- directed part ----
    // ring still empty: reads back zero
    send_beat(dbeat(FUNC_READ_RING, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    // code breakpoints at the extremes, slot 3 and slot 7 on the same address
    send_beat(dbeat(FUNC_LOAD_BP, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_LOAD_BP, 6'd7, 1'b0, 16'h0000, 16'h0000, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_LOAD_BP, 6'd3, 1'b0, 16'h0000, 16'h0000, '0, '0, '0, '0, '0, '0));
    // slot beyond the table is ignored
    send_beat(dbeat(FUNC_LOAD_BP, 6'd63, 1'b0, 16'h1234, 16'h5678, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'h0000, 16'h0000, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'h1234, 16'h5678, '0, '0, '0, '0, '0, '0));
    // log-only over everything, a one-byte pausing range, an inverted range
    send_beat(dbeat(FUNC_LOAD_WATCH, 6'd1, 1'b0, '0, '0, 20'h00000, 20'hFFFFF,
                    '0, '0, '0, '0));
    send_beat(dbeat(FUNC_LOAD_WATCH, 6'd2, 1'b1, '0, '0, 20'h12345, 20'h12345,
                    '0, '0, '0, '0));
    send_beat(dbeat(FUNC_LOAD_WATCH, 6'd4, 1'b1, '0, '0, 20'h80000, 20'h7FFFF,
                    '0, '0, '0, '0));
    send_beat(dbeat(FUNC_MEMWRITE, 6'd0, 1'b0, '0, '0, 20'h12345, '0,
                    8'h00, 8'hFF, '0, '0));
    // byte left unchanged never triggers
    send_beat(dbeat(FUNC_MEMWRITE, 6'd0, 1'b0, '0, '0, 20'h12345, '0,
                    8'hAA, 8'hAA, '0, '0));
    send_beat(dbeat(FUNC_MEMWRITE, 6'd0, 1'b0, '0, '0, 20'h80000, '0,
                    8'hFF, 8'h00, '0, '0));
    // interrupt breakpoints: one filtered on ah, one taking any ah
    send_beat(dbeat(FUNC_LOAD_INTBP, 6'd5, 1'b0, '0, '0, '0, '0, '0, '0,
                    8'hFF, 16'h1200));
    send_beat(dbeat(FUNC_LOAD_INTBP, 6'd6, 1'b1, '0, '0, '0, '0, '0, '0,
                    8'h21, 16'h0000));
    send_beat(dbeat(FUNC_INTERRUPT, 6'd0, 1'b0, 16'hFFFF, 16'h0000, '0, '0, '0, '0,
                    8'hFF, 16'h12FF));
    send_beat(dbeat(FUNC_INTERRUPT, 6'd0, 1'b0, 16'h0000, 16'hFFFF, '0, '0, '0, '0,
                    8'hFF, 16'h3400));
    send_beat(dbeat(FUNC_INTERRUPT, 6'd0, 1'b0, 16'h0000, 16'h0000, '0, '0, '0, '0,
                    8'h21, 16'hFFFF));
    send_beat(dbeat(FUNC_READ_RING, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_READ_RING, 6'd63, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    // step: arm, move to pending, trap; then a step cancelled by continue
    send_beat(dbeat(FUNC_STEP, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_STEP, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_CONTINUE, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));
    // unused function code
    send_beat(dbeat(4'd15, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));

    // disabled unit: events do nothing, commands still act
    settle();
    cfg_write(32'd0);
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_MEMWRITE, 6'd0, 1'b0, '0, '0, 20'h12345, '0,
                    8'h01, 8'h02, '0, '0));
    send_beat(dbeat(FUNC_INTERRUPT, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0,
                    8'hFF, 16'h12FF));
    send_beat(dbeat(FUNC_READ_RING, 6'd1, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_beat(dbeat(FUNC_CLEARALL, 6'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
    settle();
    cfg_write(32'd1);
    // tables gone after clear all, ring kept
    send_beat(dbeat(FUNC_INSN, 6'd0, 1'b0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, '0, '0));

    // ---- random part: three back-pressure profiles, each opened disabled ----
    for (int p = 0; p < 3; p++) begin
      settle();
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      cfg_write(32'd0);
      repeat (40) send_beat(random_beat());
      settle();
      cfg_write(32'd1);
      repeat (160) send_beat(random_beat());
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dtu_pkg.sv
rtl/debug_trigger_unit_core.sv
tb/tb_top.sv
